@@ rtl/core/hmma_pkg.sv @@
// Shared types and constants for the handheld memory map access block.
// No dependencies; imported by every module of the block.
package hmma_pkg;

  // Bus access mode codes as they arrive on mode_i
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // Access size codes; anything else is taken as a word
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Fixed memory map constants
  localparam logic [31:0] IO_BASE      = 32'h0400_0000;
  localparam logic [24:0] CART_MASK    = 25'h1FF_FFFF;
  localparam logic [16:0] VIDEO_WINDOW = 17'h1_FFFF;
  localparam logic [17:0] VIDEO_FOLD   = 18'h0_8000;
  localparam int          SMALL_BYTES  = 1024;
  localparam int          SMALL_AW     = 10;
  localparam int          CFG_W        = 21;

  // Region selects on the top address byte
  localparam logic [7:0] TOP_BOOT    = 8'h00;
  localparam logic [7:0] TOP_EXT     = 8'h02;
  localparam logic [7:0] TOP_INT     = 8'h03;
  localparam logic [7:0] TOP_IO      = IO_BASE[31:24];
  localparam logic [7:0] TOP_PAL     = 8'h05;
  localparam logic [7:0] TOP_VID     = 8'h06;
  localparam logic [7:0] TOP_OBJ     = 8'h07;
  localparam logic [7:0] TOP_CART_LO = 8'h08;
  localparam logic [7:0] TOP_CART_HI = 8'h0D;
  localparam logic [7:0] TOP_SAVE    = 8'h0E;

  // Job queue between decode and execution
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_BOOT,
    REG_EXT,
    REG_INT,
    REG_IO,
    REG_PAL,
    REG_VID,
    REG_OBJ,
    REG_CART,
    REG_SAVE
  } region_e;

  // One decoded access; addr is force-aligned, low 25 bits only
  typedef struct packed {
    op_e         op;
    region_e     region;
    logic [1:0]  last;
    logic [24:0] addr;
    logic [31:0] data;
  } hmma_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hmma_qstat_t;

endpackage

@@ rtl/core/handheld_memory_map_access.sv @@
// Top level of the handheld memory map access block: config register,
// decode front end, job queue and byte-serial back end. Depends on hmma_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | mode_i, access_size_i, bus_address_i,
//          |           |                     | store_data_i
//  out     | source    | out_valid_o/out_stall_i | fetched_data_o
//  cfg     | sink      | cfg_we_i            | cfg_data_i (cartridge length in bytes)
//
// Each beat is executed one byte at a time, then the last read byte is
// gathered; beats follow back to back while the output is free. This pace
// is set by the single byte-wide port of each store.
// After reset every store is swept to zero, one byte of each store per
// cycle, until the sweep address has covered the largest store; in_stall_o
// stays high during the sweep, cfg writes are taken.
// Up to two decoded beats queue behind the executor; a stalled result is
// held in the output register while the queue keeps filling.
module handheld_memory_map_access #(
  parameter int BOOT_BYTES     = 16384,
  parameter int EXT_WORK_BYTES = 262144,
  parameter int INT_WORK_BYTES = 32768,
  parameter int VIDEO_BYTES    = 98304,
  parameter int SAVE_BYTES     = 65536,
  parameter int CART_BYTES     = 1048576
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hmma_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [1:0]                 access_size_i,
  input  logic [31:0]                bus_address_i,
  input  logic [31:0]                store_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                fetched_data_o
);
  import hmma_pkg::*;

  // cartridge length, bytes; reads at or past it return zero
  logic [CFG_W-1:0] cart_len_q;

  hmma_qstat_t qstat;
  hmma_job_t   push_job, head_job;
  logic        push, pop, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_len_q <= '0;
    end else if (cfg_we_i) begin
      cart_len_q <= cfg_data_i;
    end
  end

  // decode: size alignment, mode and region of the top address byte
  hmma_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .access_size_i (access_size_i),
    .bus_address_i (bus_address_i),
    .store_data_i  (store_data_i),
    .clearing_i    (clearing),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (push_job)
  );

  // lets decode carry on while the executor is busy or the result stalls
  hmma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  // byte-serial execution against the stores, little-endian assembly
  hmma_back #(
    .BOOT_BYTES     (BOOT_BYTES),
    .EXT_WORK_BYTES (EXT_WORK_BYTES),
    .INT_WORK_BYTES (INT_WORK_BYTES),
    .VIDEO_BYTES    (VIDEO_BYTES),
    .SAVE_BYTES     (SAVE_BYTES),
    .CART_BYTES     (CART_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cart_len_i     (cart_len_q),
    .qstat_i        (qstat),
    .job_i          (head_job),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fetched_data_o (fetched_data_o)
  );

endmodule

@@ rtl/core/hmma_front.sv @@
// Front end: takes bus beats, decodes mode, size and region into a job.
// Depends on hmma_pkg.
module hmma_front (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic [1:0]             access_size_i,
  input  logic [31:0]            bus_address_i,
  input  logic [31:0]            store_data_i,
  input  logic                   clearing_i,
  input  hmma_pkg::hmma_qstat_t  qstat_i,
  output logic                   push_o,
  output hmma_pkg::hmma_job_t    job_o
);
  import hmma_pkg::*;

  logic [7:0] top;

  assign top        = bus_address_i[31:24];
  assign in_stall_o = clearing_i | qstat_i.full;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    job_o.data = store_data_i;

    case (mode_i)
      MODE_READ:  job_o.op = OP_READ;
      MODE_WRITE: job_o.op = OP_WRITE;
      MODE_LOAD:  job_o.op = OP_LOAD;
      default:    job_o.op = OP_NONE;
    endcase

    case (access_size_i)
      SIZE_BYTE: begin
        job_o.last = 2'd0;
        job_o.addr = bus_address_i[24:0];
      end
      SIZE_HALF: begin
        job_o.last = 2'd1;
        job_o.addr = {bus_address_i[24:1], 1'b0};
      end
      default: begin
        job_o.last = 2'd3;
        job_o.addr = {bus_address_i[24:2], 2'b00};
      end
    endcase

    if (top inside {[TOP_CART_LO:TOP_CART_HI]}) begin
      job_o.region = REG_CART;
    end else begin
      case (top)
        TOP_BOOT: job_o.region = REG_BOOT;
        TOP_EXT:  job_o.region = REG_EXT;
        TOP_INT:  job_o.region = REG_INT;
        TOP_IO:   job_o.region = REG_IO;
        TOP_PAL:  job_o.region = REG_PAL;
        TOP_VID:  job_o.region = REG_VID;
        TOP_OBJ:  job_o.region = REG_OBJ;
        TOP_SAVE: job_o.region = REG_SAVE;
        default:  job_o.region = REG_NONE;
      endcase
    end
  end

endmodule

@@ rtl/core/hmma_queue.sv @@
// Short job FIFO decoupling decode from execution.
// Depends on hmma_pkg.
module hmma_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hmma_pkg::hmma_job_t    job_i,
  input  logic                   pop_i,
  output hmma_pkg::hmma_job_t    job_o,
  output hmma_pkg::hmma_qstat_t  qstat_o
);
  import hmma_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  hmma_job_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CNT_FULL);
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign job_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ rtl/core/hmma_back.sv @@
// Back end: byte-serial executor over the nine byte stores, clear sweep,
// result register. Depends on hmma_pkg.
module hmma_back #(
  parameter int BOOT_BYTES     = 16384,
  parameter int EXT_WORK_BYTES = 262144,
  parameter int INT_WORK_BYTES = 32768,
  parameter int VIDEO_BYTES    = 98304,
  parameter int SAVE_BYTES     = 65536,
  parameter int CART_BYTES     = 1048576
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hmma_pkg::CFG_W-1:0]  cart_len_i,
  input  hmma_pkg::hmma_qstat_t       qstat_i,
  input  hmma_pkg::hmma_job_t         job_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 fetched_data_o
);
  import hmma_pkg::*;

  localparam int BOOT_AW  = $clog2(BOOT_BYTES);
  localparam int EXT_AW   = $clog2(EXT_WORK_BYTES);
  localparam int INT_AW   = $clog2(INT_WORK_BYTES);
  localparam int VIDEO_AW = $clog2(VIDEO_BYTES);
  localparam int SAVE_AW  = $clog2(SAVE_BYTES);
  localparam int CART_AW  = $clog2(CART_BYTES);

  localparam int MAX_A     = (BOOT_BYTES > EXT_WORK_BYTES) ? BOOT_BYTES : EXT_WORK_BYTES;
  localparam int MAX_B     = (MAX_A > INT_WORK_BYTES) ? MAX_A : INT_WORK_BYTES;
  localparam int MAX_C     = (MAX_B > VIDEO_BYTES) ? MAX_B : VIDEO_BYTES;
  localparam int MAX_D     = (MAX_C > SAVE_BYTES) ? MAX_C : SAVE_BYTES;
  localparam int MAX_BYTES = (MAX_D > CART_BYTES) ? MAX_D : CART_BYTES;
  localparam int CLR_W     = $clog2(MAX_BYTES);

  localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(MAX_BYTES - 1);
  localparam logic [CLR_W:0]   BOOT_CLIM  = BOOT_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   EXT_CLIM   = EXT_WORK_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   INT_CLIM   = INT_WORK_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   SMALL_CLIM = SMALL_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   VID_CLIM   = VIDEO_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   SAVE_CLIM  = SAVE_BYTES[CLR_W:0];
  localparam logic [CLR_W:0]   CART_CLIM  = CART_BYTES[CLR_W:0];

  localparam logic [23:0] EXT_MASK  = 24'(EXT_WORK_BYTES - 1);
  localparam logic [23:0] INT_MASK  = 24'(INT_WORK_BYTES - 1);
  localparam logic [23:0] SAVE_MASK = 24'(SAVE_BYTES - 1);
  localparam logic [24:0] BOOT_LIM  = 25'(BOOT_BYTES);
  localparam logic [24:0] EXT_LIM   = 25'(EXT_WORK_BYTES);
  localparam logic [24:0] INT_LIM   = 25'(INT_WORK_BYTES);
  localparam logic [24:0] SAVE_LIM  = 25'(SAVE_BYTES);
  localparam logic [23:0] SMALL_LIM = 24'(SMALL_BYTES);
  localparam logic [17:0] VID_LIM   = 18'(VIDEO_BYTES);
  localparam logic [25:0] CART_LIM  = 26'(CART_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e     st_q, st_d;
  logic       clearing_q;
  logic [CLR_W-1:0] clr_q;
  logic [CLR_W:0]   clr_x;
  hmma_job_t  job_q, job_d;
  logic [1:0] idx_q, idx_d;
  logic [31:0] acc_q, acc_d, acc_now;
  logic       out_valid_q, out_valid_d, out_free;
  logic [31:0] out_data_q, out_data_d;
  logic       rd_pend_q, rd_pend_d;
  region_e    rd_src_q;
  logic [1:0] lane_q;
  logic [7:0] fold_b, wr_byte;

  // per-byte address decode
  logic        issue, is_read, is_wr, is_load;
  logic [24:0] byte_a;
  logic [23:0] loc_a, ext_off, int_off, save_off;
  logic [17:0] vid_w, vid_f;
  logic [25:0] cart_off;
  logic        boot_hit, ext_hit, int_hit, io_hit, vid_hit, cart_rom, cart_live;
  logic        rd_hit;

  assign clearing_o     = clearing_q;
  assign out_valid_o    = out_valid_q;
  assign fetched_data_o = out_data_q;
  assign out_free       = ~out_valid_q | ~out_stall_i;
  assign clr_x          = {1'b0, clr_q};

  assign issue   = (st_q == ST_ISSUE);
  assign is_read = (job_q.op == OP_READ);
  assign is_load = (job_q.op == OP_LOAD);
  assign is_wr   = (job_q.op == OP_WRITE) | is_load;

  assign byte_a   = {job_q.addr[24:2], job_q.addr[1:0] | idx_q};
  assign loc_a    = byte_a[23:0];
  assign ext_off  = loc_a & EXT_MASK;
  assign int_off  = loc_a & INT_MASK;
  assign save_off = loc_a & SAVE_MASK;
  assign vid_w    = {1'b0, byte_a[16:0] & VIDEO_WINDOW};
  assign vid_f    = (vid_w >= VID_LIM) ? vid_w - VIDEO_FOLD : vid_w;
  assign cart_off = {1'b0, byte_a & CART_MASK};

  assign boot_hit  = {1'b0, loc_a} < BOOT_LIM;
  assign ext_hit   = {1'b0, ext_off} < EXT_LIM;
  assign int_hit   = {1'b0, int_off} < INT_LIM;
  assign io_hit    = loc_a < SMALL_LIM;
  assign vid_hit   = vid_f < VID_LIM;
  assign cart_rom  = cart_off < CART_LIM;
  assign cart_live = cart_rom & (cart_off < 26'(cart_len_i));

  logic save_hit;
  assign save_hit = {1'b0, save_off} < SAVE_LIM;

  // region hit for a read of this byte
  always_comb begin
    case (job_q.region)
      REG_BOOT: rd_hit = boot_hit;
      REG_EXT:  rd_hit = ext_hit;
      REG_INT:  rd_hit = int_hit;
      REG_IO:   rd_hit = io_hit;
      REG_PAL:  rd_hit = 1'b1;
      REG_VID:  rd_hit = vid_hit;
      REG_OBJ:  rd_hit = 1'b1;
      REG_CART: rd_hit = cart_live;
      REG_SAVE: rd_hit = save_hit;
      default:  rd_hit = 1'b0;
    endcase
  end

  assign wr_byte = clearing_q ? 8'h00 : 8'(job_q.data >> {idx_q, 3'b000});

  // ---- byte stores: one port each, registered read ----
  logic wr_go;
  assign wr_go = issue & is_wr;

  logic [BOOT_AW-1:0] boot_a;
  logic               boot_we;
  logic [7:0]         boot_mem [BOOT_BYTES];
  logic [7:0]         boot_rd_q;
  assign boot_a  = clearing_q ? clr_q[BOOT_AW-1:0] : loc_a[BOOT_AW-1:0];
  assign boot_we = clearing_q ? (clr_x < BOOT_CLIM)
                              : (issue & is_load & (job_q.region == REG_BOOT) & boot_hit);
  always_ff @(posedge clk_i) begin
    if (boot_we) boot_mem[boot_a] <= wr_byte;
    boot_rd_q <= boot_mem[boot_a];
  end

  logic [EXT_AW-1:0] ext_a;
  logic              ext_we;
  logic [7:0]        ext_mem [EXT_WORK_BYTES];
  logic [7:0]        ext_rd_q;
  assign ext_a  = clearing_q ? clr_q[EXT_AW-1:0] : ext_off[EXT_AW-1:0];
  assign ext_we = clearing_q ? (clr_x < EXT_CLIM)
                             : (wr_go & (job_q.region == REG_EXT) & ext_hit);
  always_ff @(posedge clk_i) begin
    if (ext_we) ext_mem[ext_a] <= wr_byte;
    ext_rd_q <= ext_mem[ext_a];
  end

  logic [INT_AW-1:0] int_a;
  logic              int_we;
  logic [7:0]        int_mem [INT_WORK_BYTES];
  logic [7:0]        int_rd_q;
  assign int_a  = clearing_q ? clr_q[INT_AW-1:0] : int_off[INT_AW-1:0];
  assign int_we = clearing_q ? (clr_x < INT_CLIM)
                             : (wr_go & (job_q.region == REG_INT) & int_hit);
  always_ff @(posedge clk_i) begin
    if (int_we) int_mem[int_a] <= wr_byte;
    int_rd_q <= int_mem[int_a];
  end

  logic [SMALL_AW-1:0] small_a;
  assign small_a = clearing_q ? clr_q[SMALL_AW-1:0] : loc_a[SMALL_AW-1:0];

  logic       io_we;
  logic [7:0] io_mem [SMALL_BYTES];
  logic [7:0] io_rd_q;
  assign io_we = clearing_q ? (clr_x < SMALL_CLIM)
                            : (wr_go & (job_q.region == REG_IO) & io_hit);
  always_ff @(posedge clk_i) begin
    if (io_we) io_mem[small_a] <= wr_byte;
    io_rd_q <= io_mem[small_a];
  end

  logic       pal_we;
  logic [7:0] pal_mem [SMALL_BYTES];
  logic [7:0] pal_rd_q;
  assign pal_we = clearing_q ? (clr_x < SMALL_CLIM) : (wr_go & (job_q.region == REG_PAL));
  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[small_a] <= wr_byte;
    pal_rd_q <= pal_mem[small_a];
  end

  logic       obj_we;
  logic [7:0] obj_mem [SMALL_BYTES];
  logic [7:0] obj_rd_q;
  assign obj_we = clearing_q ? (clr_x < SMALL_CLIM) : (wr_go & (job_q.region == REG_OBJ));
  always_ff @(posedge clk_i) begin
    if (obj_we) obj_mem[small_a] <= wr_byte;
    obj_rd_q <= obj_mem[small_a];
  end

  logic [VIDEO_AW-1:0] vid_a;
  logic                vid_we;
  logic [7:0]          vid_mem [VIDEO_BYTES];
  logic [7:0]          vid_rd_q;
  assign vid_a  = clearing_q ? clr_q[VIDEO_AW-1:0] : vid_f[VIDEO_AW-1:0];
  assign vid_we = clearing_q ? (clr_x < VID_CLIM)
                             : (wr_go & (job_q.region == REG_VID) & vid_hit);
  always_ff @(posedge clk_i) begin
    if (vid_we) vid_mem[vid_a] <= wr_byte;
    vid_rd_q <= vid_mem[vid_a];
  end

  logic [SAVE_AW-1:0] save_a;
  logic               save_we;
  logic [7:0]         save_mem [SAVE_BYTES];
  logic [7:0]         save_rd_q;
  assign save_a  = clearing_q ? clr_q[SAVE_AW-1:0] : save_off[SAVE_AW-1:0];
  assign save_we = clearing_q ? (clr_x < SAVE_CLIM)
                              : (wr_go & (job_q.region == REG_SAVE) & save_hit);
  always_ff @(posedge clk_i) begin
    if (save_we) save_mem[save_a] <= wr_byte;
    save_rd_q <= save_mem[save_a];
  end

  logic [CART_AW-1:0] cart_a;
  logic               cart_we;
  logic [7:0]         cart_mem [CART_BYTES];
  logic [7:0]         cart_rd_q;
  assign cart_a  = clearing_q ? clr_q[CART_AW-1:0] : cart_off[CART_AW-1:0];
  assign cart_we = clearing_q ? (clr_x < CART_CLIM)
                              : (issue & is_load & (job_q.region == REG_CART) & cart_rom);
  always_ff @(posedge clk_i) begin
    if (cart_we) cart_mem[cart_a] <= wr_byte;
    cart_rd_q <= cart_mem[cart_a];
  end

  // byte read last cycle, steered by the region it came from
  always_comb begin
    case (rd_src_q)
      REG_BOOT: fold_b = boot_rd_q;
      REG_EXT:  fold_b = ext_rd_q;
      REG_INT:  fold_b = int_rd_q;
      REG_IO:   fold_b = io_rd_q;
      REG_PAL:  fold_b = pal_rd_q;
      REG_VID:  fold_b = vid_rd_q;
      REG_OBJ:  fold_b = obj_rd_q;
      REG_CART: fold_b = cart_rd_q;
      REG_SAVE: fold_b = save_rd_q;
      default:  fold_b = 8'h00;
    endcase
  end

  assign acc_now   = acc_q | (rd_pend_q ? (32'(fold_b) << {lane_q, 3'b000}) : 32'h0);
  assign rd_pend_d = issue & is_read & rd_hit;

  // ---- sequencer ----
  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    job_d       = job_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;

    case (st_q)
      ST_IDLE: begin
        pop_o = ~clearing_q & ~qstat_i.empty;
      end
      ST_ISSUE: begin
        acc_d = acc_now;
        if (idx_q == job_q.last) begin
          st_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_now;
          st_d        = ST_IDLE;
          pop_o       = ~qstat_i.empty;
        end else begin
          acc_d = acc_now;
          st_d  = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          st_d        = ST_IDLE;
          pop_o       = ~qstat_i.empty;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (pop_o) begin
      job_d = job_i;
      idx_d = 2'd0;
      acc_d = 32'h0;
      st_d  = ST_ISSUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      idx_q       <= 2'd0;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == CLR_LAST) clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    rd_src_q   <= job_q.region;
    lane_q     <= idx_q;
  end

endmodule

@@ rtl/core/hmma_checker.sv @@
// Port-level checks for handheld_memory_map_access, attached by bind.
// Depends on hmma_pkg.
module hmma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] fetched_data_o
);
  import hmma_pkg::*;

  // beats held: queue, executor, output register
  localparam int HELD_MAX = QUEUE_DEPTH + 2;
  localparam int HELD_W   = $clog2(HELD_MAX + 1);
  localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(HELD_MAX);

  logic [HELD_W-1:0] held_q;
  logic              in_beat, out_beat;

  assign in_beat  = in_valid_i & ~in_stall_o;
  assign out_beat = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (in_beat && !out_beat) begin
      held_q <= held_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      held_q <= held_q - 1'b1;
    end
  end

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fetched_data_o))
    else $error("result changed under stall");

  // no result without an earlier beat still owed
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> held_q != '0)
    else $error("result with no beat outstanding");

  // all slots taken must push back on the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == HELD_FULL |-> in_stall_o)
    else $error("input taken with every slot full");

  // store sweep after reset blocks the input
  a_sweep_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open before store sweep");

endmodule

bind handheld_memory_map_access hmma_checker u_hmma_checker (.*);
